[rtl/core/gdfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types, sizes and the control program for the grid depth-first walk.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_COLS   = 8;
  localparam int VALUE_BITS = 16;
  localparam int CELLS      = MAX_ROWS * MAX_COLS;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int IDX_W      = ROW_W + COL_W;
  localparam int DEPTH_W    = IDX_W + 1;
  localparam int CFG_W      = 4;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // input kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_START = 1'b1;

  // neighbor directions, in push order
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_POP  = 3'd1;
  localparam step_t ST_LOAD = 3'd2;
  localparam step_t ST_NB0  = 3'd3;
  localparam step_t ST_NB1  = 3'd4;
  localparam step_t ST_NB2  = 3'd5;
  localparam step_t ST_NB3  = 3'd6;
  localparam step_t ST_EMIT = 3'd7;

  // CND_NEXT: step + 1; CND_LOOP: target while stack holds cells, else idle
  typedef enum logic {
    CND_NEXT,
    CND_LOOP
  } cond_t;

  typedef struct packed {
    logic       idle;
    logic       pop;
    logic       latch;
    logic       chk;
    logic [1:0] dir;
    logic       emit;
    cond_t      cond;
    step_t      target;
  } ctl_t;

  function automatic ctl_t ucode(step_t s);
    ctl_t w;
    w = '{idle: 1'b0, pop: 1'b0, latch: 1'b0, chk: 1'b0, dir: DIR_LEFT,
          emit: 1'b0, cond: CND_NEXT, target: ST_IDLE};
    case (s)
      ST_IDLE: w.idle  = 1'b1;
      ST_POP:  w.pop   = 1'b1;
      ST_LOAD: w.latch = 1'b1;
      ST_NB0: begin
        w.chk = 1'b1;
        w.dir = DIR_LEFT;
      end
      ST_NB1: begin
        w.chk = 1'b1;
        w.dir = DIR_DOWN;
      end
      ST_NB2: begin
        w.chk = 1'b1;
        w.dir = DIR_RIGHT;
      end
      ST_NB3: begin
        w.chk = 1'b1;
        w.dir = DIR_UP;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = CND_LOOP;
        w.target = ST_POP;
      end
      default: w.idle = 1'b1;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/grid_dfs_stack_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dfs_stack_walk
// Grid of signed cells with a 4-neighbor depth-first walk on an explicit stack.
// ----------------------------------------------------------------------------
//  group  | dir | payload                                        | moves on
//  in_    | in  | tuser: cmd; tdata: row, col, value             | tvalid & tready
//  out_   | out | tdata: cell_value, cell_row, cell_col;         | tvalid & tready
//         |     | tlast: last; tuser: error                      |
//  cfg_   | in  | addr 0 rows_in_use, addr 1 cols_in_use         | cfg_we
//
// A cell write goes straight into the grid RAM. A start walks the area under
// a microcode program: pop, stack read, four neighbor steps, emit, for each
// visited cell, with at most one stack push per neighbor step and registered
// reads of the stack and grid RAMs; the emit step waits while the result
// register is held by out_tready. A bad start gives its error result in the
// next cycle. Reset clears the visited map, the stack depth and sets a 4 x 4
// area; grid and stack RAM are not cleared.
// ----------------------------------------------------------------------------
module grid_dfs_stack_walk
  import gdfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
  input  logic        in_tuser,   // cmd
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // cell_value[15:0], cell_row[18:16],
                                  // cell_col[21:19], zero pad
  output logic        out_tlast,
  output logic        out_tuser   // error
);

  // configuration
  logic [CFG_W-1:0] rows_in_use_r, cols_in_use_r;
  logic [CFG_W-1:0] nrows, ncols;

  // sequencer and datapath
  step_t              pc_r, pc_nxt;
  ctl_t               ctl;
  logic [DEPTH_W-1:0] sp_r, sp_nxt;
  logic [CELLS-1:0]   visited_r, visited_nxt;
  logic [ROW_W-1:0]   cur_row_r;
  logic [COL_W-1:0]   cur_col_r;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [ROW_W-1:0]      out_row_r;
  logic [COL_W-1:0]      out_col_r;
  logic                  out_last_r, out_err_r;
  logic                  out_free;

  // request fields
  logic                  in_fire;
  logic                  in_cmd;
  logic [ROW_W-1:0]      in_row;
  logic [COL_W-1:0]      in_col;
  logic [VALUE_BITS-1:0] in_value;
  logic                  start_bad, start_ok;

  // neighbor check
  logic             nb_ok, push;
  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;

  // memories
  logic             grid_we;
  logic [IDX_W-1:0] grid_waddr, grid_raddr;
  logic [VALUE_BITS-1:0] grid_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic [DEPTH_W-1:0] sp_dec;

  assign nrows = (rows_in_use_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_in_use_r;
  assign ncols = (cols_in_use_r > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_in_use_r;

  assign ctl      = ucode(pc_r);
  assign out_free = !out_valid_r || out_tready;

  assign in_cmd   = in_tuser;
  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[21:6];

  assign in_tready = ctl.idle && out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign start_bad = ({1'b0, in_row} >= nrows) || ({1'b0, in_col} >= ncols);
  assign start_ok  = in_fire && (in_cmd == CMD_START) && !start_bad;

  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    case (ctl.dir)
      DIR_LEFT: begin
        nb_col = cur_col_r - COL_W'(1);
        nb_ok  = (cur_col_r != '0);
      end
      DIR_DOWN: begin
        nb_row = cur_row_r + ROW_W'(1);
        nb_ok  = (({1'b0, cur_row_r}) + CFG_W'(1)) < nrows;
      end
      DIR_RIGHT: begin
        nb_col = cur_col_r + COL_W'(1);
        nb_ok  = (({1'b0, cur_col_r}) + CFG_W'(1)) < ncols;
      end
      DIR_UP: begin
        nb_row = cur_row_r - ROW_W'(1);
        nb_ok  = (cur_row_r != '0);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign push = ctl.chk && nb_ok && !visited_r[{nb_row, nb_col}] && !sp_r[DEPTH_W-1];

  // grid store
  assign grid_we    = in_fire && (in_cmd == CMD_WRITE);
  assign grid_waddr = {in_row, in_col};
  assign grid_raddr = {cur_row_r, cur_col_r};

  gdfs_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (in_value),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  // walk stack
  assign sp_dec    = sp_r - DEPTH_W'(1);
  assign stk_we    = start_ok || push;
  assign stk_waddr = start_ok ? '0 : sp_r[IDX_W-1:0];
  assign stk_wdata = start_ok ? {in_row, in_col} : {nb_row, nb_col};
  assign stk_raddr = sp_dec[IDX_W-1:0];

  gdfs_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    pc_nxt        = pc_r;
    sp_nxt        = sp_r;
    visited_nxt   = visited_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (ctl.idle) begin
      if (start_ok) begin
        visited_nxt                   = '0;
        visited_nxt[{in_row, in_col}] = 1'b1;
        sp_nxt                        = DEPTH_W'(1);
        pc_nxt                        = ST_POP;
      end else if (in_fire && (in_cmd == CMD_START)) begin
        out_valid_nxt = 1'b1;
      end
    end else if (ctl.emit) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        pc_nxt        = (ctl.cond == CND_LOOP && sp_r != '0) ? ctl.target : ST_IDLE;
      end
    end else begin
      pc_nxt = pc_r + step_t'(1);
      if (ctl.pop) begin
        sp_nxt = sp_dec;
      end
      if (push) begin
        sp_nxt                        = sp_r + DEPTH_W'(1);
        visited_nxt[{nb_row, nb_col}] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= ST_IDLE;
      sp_r          <= '0;
      visited_r     <= '0;
      out_valid_r   <= 1'b0;
      rows_in_use_r <= CFG_W'(4);
      cols_in_use_r <= CFG_W'(4);
    end else begin
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ROWS: rows_in_use_r <= cfg_wdata;
          CFG_COLS: cols_in_use_r <= cfg_wdata;
          default:  rows_in_use_r <= rows_in_use_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cur_row_r <= stk_rdata[IDX_W-1:COL_W];
      cur_col_r <= stk_rdata[COL_W-1:0];
    end
    if (ctl.idle && in_fire && (in_cmd == CMD_START) && start_bad) begin
      out_value_r <= '0;
      out_row_r   <= in_row;
      out_col_r   <= in_col;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end else if (ctl.emit && out_free) begin
      out_value_r <= grid_rdata;
      out_row_r   <= cur_row_r;
      out_col_r   <= cur_col_r;
      out_last_r  <= (sp_r == '0);
      out_err_r   <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_value_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= DEPTH_W'(CELLS))
    else $error("stack depth beyond grid size");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == ST_IDLE) |-> (sp_r == '0))
    else $error("sequencer idle with cells on the stack");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("error result without last");

  a_push_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> visited_r[$past({nb_row, nb_col})])
    else $error("pushed cell not marked visited");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && out_free && sp_r == '0) |=> (pc_r == ST_IDLE))
    else $error("walk continued after final result");

endmodule

[rtl/core/gdfs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gdfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
